// ----- src/pfx_pkg.sv -----
// Package for the postfix expression evaluator: payload structs, status codes,
// character codes and sizing constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pfx_pkg;

  localparam int unsigned DataW      = 32;
  localparam int unsigned StackDepth = 16;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_OVER  = 3'd2;
  localparam logic [2:0] ST_DIVZ  = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
  } out_req_t;

  // Control from the top level to the arithmetic unit.
  typedef struct packed {
    logic       start;
    logic [7:0] op;
  } alu_ctl_t;

  // Status from the arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
    logic divz;
  } alu_sts_t;

endpackage
`default_nettype wire

// ----- src/pfx_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pfx_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end
endmodule
`default_nettype wire

// ----- src/pfx_alu.sv -----
// Bit-serial arithmetic unit: shift-add multiply and restoring divide, one bit
// per cycle; add and subtract need no bit-serial steps. Depends on pfx_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pfx_alu (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pfx_pkg::alu_ctl_t   ctl,
  input  wire logic [31:0]         a,
  input  wire logic [31:0]         b,
  output pfx_pkg::alu_sts_t        sts,
  output logic [31:0]              result
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] acc_r, acc_nxt;     // product, or quotient bits shifted in
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] sa_r, sa_nxt;       // multiplicand or dividend magnitude
  logic [31:0] sb_r, sb_nxt;       // multiplier or divisor magnitude
  logic        neg_r, neg_nxt;
  logic        divz_r, divz_nxt;
  logic [32:0] trial;
  logic [31:0] rem_sh;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    sa_nxt    = sa_r;
    sb_nxt    = sb_r;
    neg_nxt   = neg_r;
    divz_nxt  = divz_r;
    rem_sh    = {rem_r[30:0], sa_r[31]};
    trial     = {1'b0, rem_sh} - {1'b0, sb_r};
    unique case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          divz_nxt = 1'b0;
          cnt_nxt  = 5'd0;
          priority if (ctl.op == pfx_pkg::CH_PLUS) begin
            acc_nxt = a + b;  state_nxt = S_FIN;
          end else if (ctl.op == pfx_pkg::CH_MINUS) begin
            acc_nxt = a - b;  state_nxt = S_FIN;
          end else if (ctl.op == pfx_pkg::CH_MUL) begin
            acc_nxt = '0; sa_nxt = a; sb_nxt = b; state_nxt = S_MUL;
          end else if (ctl.op == pfx_pkg::CH_DIV) begin
            if (b == '0) begin
              acc_nxt = '0; divz_nxt = 1'b1; state_nxt = S_FIN;
            end else begin
              sa_nxt  = a[31] ? (~a + 32'd1) : a;
              sb_nxt  = b[31] ? (~b + 32'd1) : b;
              neg_nxt = a[31] ^ b[31];
              acc_nxt = '0; rem_nxt = '0; state_nxt = S_DIV;
            end
          end else begin
            acc_nxt = '0; state_nxt = S_FIN;
          end
        end
      end
      S_MUL: begin
        if (sb_r[0]) begin
          acc_nxt = acc_r + sa_r;
        end
        sa_nxt  = {sa_r[30:0], 1'b0};
        sb_nxt  = {1'b0, sb_r[31:1]};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          state_nxt = S_FIN;
        end
      end
      S_DIV: begin
        if (!trial[32]) begin
          rem_nxt = trial[31:0];
        end else begin
          rem_nxt = rem_sh;
        end
        acc_nxt = {acc_r[30:0], ~trial[32]};
        sa_nxt  = {sa_r[30:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (neg_r) begin
          acc_nxt = ~acc_r + 32'd1;
        end
        neg_nxt   = 1'b0;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      neg_r   <= 1'b0;
      divz_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      neg_r   <= neg_nxt;
      divz_r  <= divz_nxt;
    end
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    sa_r  <= sa_nxt;
    sb_r  <= sb_nxt;
  end

  always_comb begin
    sts.busy = (state_r != S_IDLE);
    sts.done = (state_r == S_FIN);
    sts.divz = divz_r;
    result   = neg_r ? (~acc_r + 32'd1) : acc_r;
  end
endmodule
`default_nettype wire

// ----- src/postfix_expression_evaluator.sv -----
// Postfix evaluator top level. A digit, a skipped character or an operator that
// underflows needs no further step; a space pushes the number; any other operator
// pops two operands, runs the unit (bit-serial for * and /, one bit a cycle) and
// pushes the result; the last character then reads the top of the stack and loads
// the result, waiting while the output register is held. One character is in work at a
// time. Synchronous active-low reset clears all control state; stack contents are
// undefined until written. Depends on pfx_pkg, pfx_alu and pfx_ram.
`timescale 1ns / 1ps
`default_nettype none
module postfix_expression_evaluator #(
  parameter int unsigned STACK_DEPTH = pfx_pkg::StackDepth
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pfx_pkg::in_req_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pfx_pkg::out_req_t      out_data
);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_POPB  = 4'd1;  // read right operand
  localparam logic [3:0] S_POPA  = 4'd2;  // latch b, read left operand
  localparam logic [3:0] S_GETA  = 4'd3;  // latch a
  localparam logic [3:0] S_ALU   = 4'd4;
  localparam logic [3:0] S_PUSH  = 4'd5;
  localparam logic [3:0] S_TOP   = 4'd6;  // read top of stack for a result
  localparam logic [3:0] S_TOPW  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;  // wait for the output register

  logic [3:0]    state_r, state_nxt;
  logic [31:0]   num_r, num_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          skip_r, skip_nxt;
  logic [2:0]    sts_r, sts_nxt;
  logic          last_r, last_nxt;
  logic [7:0]    op_r, op_nxt;
  logic [31:0]   opa_r, opa_nxt, opb_r, opb_nxt;
  logic [31:0]   pushv_r, pushv_nxt;
  logic          ov_r, ov_nxt;
  pfx_pkg::out_req_t res_r, res_nxt;
  logic          resv_r, resv_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_wdata, ram_rdata;

  pfx_pkg::alu_ctl_t alu_ctl;
  pfx_pkg::alu_sts_t alu_sts;
  logic [31:0]       alu_res;

  logic accept, is_digit;
  logic [3:0] digit;

  pfx_ram #(.WIDTH(pfx_pkg::DataW), .DEPTH(STACK_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  pfx_alu u_alu (
    .clk(clk), .rst_n(rst_n), .ctl(alu_ctl), .a(opa_r), .b(opb_r),
    .sts(alu_sts), .result(alu_res)
  );

  // Output register slot frees when the held result is taken.
  logic out_free;
  assign out_free = !resv_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_digit = (in_data.ch >= pfx_pkg::CH_ZERO) && (in_data.ch <= pfx_pkg::CH_NINE);
  assign digit    = 4'(in_data.ch - pfx_pkg::CH_ZERO);

  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    cnt_nxt   = cnt_r;
    skip_nxt  = skip_r;
    sts_nxt   = sts_r;
    last_nxt  = last_r;
    op_nxt    = op_r;
    opa_nxt   = opa_r;
    opb_nxt   = opb_r;
    pushv_nxt = pushv_r;
    ov_nxt    = ov_r;
    res_nxt   = res_r;
    resv_nxt  = resv_r && out_stall;
    ram_we    = 1'b0;
    ram_addr  = cnt_r[AW-1:0];
    ram_wdata = pushv_r;
    alu_ctl.start = 1'b0;
    alu_ctl.op    = op_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          last_nxt  = in_data.last;
          state_nxt = in_data.last ? S_TOP : S_IDLE;
          if (skip_r) begin
            skip_nxt = 1'b0;
          end else if (is_digit) begin
            // Multiply by ten as two shifts and an add.
            num_nxt = {num_r[28:0], 3'b000} + {num_r[30:0], 1'b0} + 32'(digit);
          end else if (in_data.ch == pfx_pkg::CH_SPACE) begin
            pushv_nxt = num_r;
            num_nxt   = '0;
            state_nxt = S_PUSH;
          end else begin
            skip_nxt = 1'b1;
            if (cnt_r < CW'(2)) begin
              if (sts_r == pfx_pkg::ST_OK) begin
                sts_nxt = pfx_pkg::ST_UNDER;
              end
            end else begin
              op_nxt    = in_data.ch;
              cnt_nxt   = cnt_r - CW'(1);
              state_nxt = S_POPB;
            end
          end
        end
      end
      S_POPB: begin
        cnt_nxt   = cnt_r - CW'(1);
        state_nxt = S_POPA;
      end
      S_POPA: begin
        opb_nxt   = ram_rdata;
        state_nxt = S_GETA;
      end
      S_GETA: begin
        opa_nxt       = ram_rdata;
        state_nxt     = S_ALU;
      end
      S_ALU: begin
        // Start the unit once, on the first cycle in this state.
        alu_ctl.start = !ov_r && !alu_sts.busy;
        ov_nxt        = 1'b1;
        if (alu_sts.done) begin
          ov_nxt    = 1'b0;
          pushv_nxt = alu_res;
          if (alu_sts.divz && (sts_r == pfx_pkg::ST_OK)) begin
            sts_nxt = pfx_pkg::ST_DIVZ;
          end
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (cnt_r >= FULL) begin
          if (sts_r == pfx_pkg::ST_OK) begin
            sts_nxt = pfx_pkg::ST_OVER;
          end
        end else begin
          ram_we  = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
        state_nxt = last_r ? S_TOP : S_IDLE;
      end
      S_TOP: begin
        ram_addr  = AW'(cnt_r - CW'(1));
        state_nxt = S_TOPW;
      end
      S_TOPW: begin
        ram_addr  = AW'(cnt_r - CW'(1));
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // Keep reading the top entry so the read data holds while waiting.
        ram_addr = AW'(cnt_r - CW'(1));
        if (out_free) begin
          res_nxt.value  = (cnt_r != '0) ? ram_rdata : '0;
          res_nxt.status = ((cnt_r == '0) && (sts_r == pfx_pkg::ST_OK)) ?
                           pfx_pkg::ST_EMPTY : sts_r;
          resv_nxt  = 1'b1;
          num_nxt   = '0;
          cnt_nxt   = '0;
          skip_nxt  = 1'b0;
          sts_nxt   = pfx_pkg::ST_OK;
          last_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      num_r   <= '0;
      cnt_r   <= '0;
      skip_r  <= 1'b0;
      sts_r   <= pfx_pkg::ST_OK;
      last_r  <= 1'b0;
      ov_r    <= 1'b0;
      resv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      num_r   <= num_nxt;
      cnt_r   <= cnt_nxt;
      skip_r  <= skip_nxt;
      sts_r   <= sts_nxt;
      last_r  <= last_nxt;
      ov_r    <= ov_nxt;
      resv_r  <= resv_nxt;
    end
    op_r    <= op_nxt;
    opa_r   <= opa_nxt;
    opb_r   <= opb_nxt;
    pushv_r <= pushv_nxt;
    res_r   <= res_nxt;
  end

  assign out_valid = resv_r;
  assign out_data  = res_r;

  // The stack never holds more entries than its depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL) else $error("stack count beyond depth");

  // A new result is only loaded in the output stage.
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    (resv_nxt && !(resv_r && out_stall)) |-> state_r == S_OUT)
    else $error("result loaded outside output stage");

  // Input is never taken while an operator is in flight.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALU) |-> in_stall) else $error("accept during arithmetic");
endmodule
`default_nettype wire
